### rtl/a64eu_pkg.sv
// ----------------------------------------------------------------------------
// a64eu_pkg
// Shared types and constants of the A64 integer subset execute unit.
// ----------------------------------------------------------------------------
package a64eu_pkg;

  localparam int XLEN       = 64;
  localparam int WORD_W     = 32;
  localparam int OP_W       = 5;
  localparam int REG_ADDR_W = 5;
  localparam int NUM_REGS   = 32;
  localparam int HALF_W     = XLEN / 2;

  localparam logic [REG_ADDR_W-1:0] ZERO_REG = 5'd31;

  // Program counter value that reset establishes for start_pc.
  localparam logic [XLEN-1:0] START_PC_RST = '0;

  // imms value that selects a logical right shift.
  localparam logic [5:0] SHIFT_RIGHT_SEL = 6'd63;

  localparam logic [XLEN-1:0] PC_STEP = 64'd4;

  typedef enum logic [OP_W-1:0] {
    OP_ADDS_IMM = 5'd0,
    OP_ADDS_REG = 5'd1,
    OP_SUBS_IMM = 5'd2,
    OP_SUBS_REG = 5'd3,
    OP_CMP_IMM  = 5'd4,
    OP_CMP_REG  = 5'd5,
    OP_ANDS     = 5'd6,
    OP_EOR      = 5'd7,
    OP_ORR      = 5'd8,
    OP_B        = 5'd9,
    OP_BR       = 5'd10,
    OP_B_COND   = 5'd11,
    OP_SHIFT    = 5'd12,
    OP_MOVZ     = 5'd13,
    OP_ADD_IMM  = 5'd14,
    OP_ADD_REG  = 5'd15,
    OP_MADD     = 5'd16,
    OP_HLT      = 5'd17
  } op_t;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13
  } cond_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic            write;
    logic [XLEN-1:0] value;
    logic            set_flags;
    logic            neg;
    logic            zero;
    logic            halt;
  } alu_res_t;

endpackage

### rtl/a64eu_in_if.sv
// ----------------------------------------------------------------------------
// a64eu_in_if
// Instruction channel: op selector and raw instruction word.
// ----------------------------------------------------------------------------
interface a64eu_in_if;
  logic                          valid;
  logic                          ready;
  logic [a64eu_pkg::OP_W-1:0]    op;
  logic [a64eu_pkg::WORD_W-1:0]  instr_word;

  modport source (output valid, output op, output instr_word, input ready);
  modport sink   (input valid, input op, input instr_word, output ready);
endinterface

### rtl/a64eu_out_if.sv
// ----------------------------------------------------------------------------
// a64eu_out_if
// Result channel: architectural effects of one retired instruction.
// ----------------------------------------------------------------------------
interface a64eu_out_if;
  logic                              valid;
  logic                              ready;
  logic [a64eu_pkg::XLEN-1:0]        next_pc;
  logic                              branch_taken;
  logic                              reg_written;
  logic [a64eu_pkg::REG_ADDR_W-1:0]  dest_index;
  logic [a64eu_pkg::XLEN-1:0]        dest_value;
  logic                              neg_flag;
  logic                              zero_flag;
  logic                              halted;

  modport source (output valid, output next_pc, output branch_taken, output reg_written,
                  output dest_index, output dest_value, output neg_flag, output zero_flag,
                  output halted, input ready);
  modport sink   (input valid, input next_pc, input branch_taken, input reg_written,
                  input dest_index, input dest_value, input neg_flag, input zero_flag,
                  input halted, output ready);
endinterface

### rtl/a64eu_cfg_if.sv
// ----------------------------------------------------------------------------
// a64eu_cfg_if
// Configuration write channel carrying the start_pc value.
// ----------------------------------------------------------------------------
interface a64eu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [a64eu_pkg::XLEN-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/a64eu_regfile.sv
// ----------------------------------------------------------------------------
// a64eu_regfile
// 32 x 64 register file, two banks with one write port each and registered
// reads, write-through on a same-cycle write, and valid bits for reset.
// ----------------------------------------------------------------------------
module a64eu_regfile (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_en,
  input  logic [a64eu_pkg::REG_ADDR_W-1:0]    rn_addr,
  input  logic [a64eu_pkg::REG_ADDR_W-1:0]    rm_addr,
  input  logic [a64eu_pkg::REG_ADDR_W-1:0]    ra_addr,
  input  logic                                we,
  input  logic [a64eu_pkg::REG_ADDR_W-1:0]    waddr,
  input  logic [a64eu_pkg::XLEN-1:0]          wdata,
  output logic [a64eu_pkg::XLEN-1:0]          rn_data,
  output logic [a64eu_pkg::XLEN-1:0]          rm_data,
  output logic [a64eu_pkg::XLEN-1:0]          ra_data
);

  // Bank A serves rn and rm, bank B serves the madd addend.
  logic [a64eu_pkg::XLEN-1:0]     mem_a [a64eu_pkg::NUM_REGS];
  logic [a64eu_pkg::XLEN-1:0]     mem_b [a64eu_pkg::NUM_REGS];
  logic [a64eu_pkg::NUM_REGS-1:0] valid_r;
  logic [a64eu_pkg::XLEN-1:0]     rn_data_r;
  logic [a64eu_pkg::XLEN-1:0]     rm_data_r;
  logic [a64eu_pkg::XLEN-1:0]     ra_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
    end
  end

  // Register 31 is never written, so its valid bit stays low and it reads zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && waddr == rn_addr) begin
        rn_data_r <= wdata;
      end else if (valid_r[rn_addr]) begin
        rn_data_r <= mem_a[rn_addr];
      end else begin
        rn_data_r <= '0;
      end
      if (we && waddr == rm_addr) begin
        rm_data_r <= wdata;
      end else if (valid_r[rm_addr]) begin
        rm_data_r <= mem_a[rm_addr];
      end else begin
        rm_data_r <= '0;
      end
      if (we && waddr == ra_addr) begin
        ra_data_r <= wdata;
      end else if (valid_r[ra_addr]) begin
        ra_data_r <= mem_b[ra_addr];
      end else begin
        ra_data_r <= '0;
      end
    end
  end

  assign rn_data = rn_data_r;
  assign rm_data = rm_data_r;
  assign ra_data = ra_data_r;

endmodule

### rtl/a64eu_alu.sv
// ----------------------------------------------------------------------------
// a64eu_alu
// Combinational execute logic: result value, flags and next program counter
// of one instruction from its operands and the architectural state.
// ----------------------------------------------------------------------------
module a64eu_alu (
  input  logic [a64eu_pkg::OP_W-1:0]    op,
  input  logic [a64eu_pkg::WORD_W-1:0]  word,
  input  logic [a64eu_pkg::XLEN-1:0]    rn_val,
  input  logic [a64eu_pkg::XLEN-1:0]    rm_val,
  input  logic [a64eu_pkg::XLEN-1:0]    madd_val,
  input  logic [a64eu_pkg::XLEN-1:0]    pc,
  input  logic                          flag_n,
  input  logic                          flag_z,
  input  logic                          running,
  output a64eu_pkg::alu_res_t           res
);

  logic [a64eu_pkg::XLEN-1:0] imm12;
  logic [a64eu_pkg::XLEN-1:0] flag_src;
  logic [a64eu_pkg::XLEN-1:0] pc_seq;
  logic [a64eu_pkg::XLEN-1:0] b_off;
  logic [a64eu_pkg::XLEN-1:0] bc_off;
  logic [a64eu_pkg::XLEN-1:0] movz_val;
  logic [5:0]                 imms;
  logic [5:0]                 immr;
  logic [5:0]                 lsl_amt;
  logic                       cond_go;

  always_comb begin
    imms     = word[15:10];
    immr     = word[21:16];
    lsl_amt  = a64eu_pkg::SHIFT_RIGHT_SEL - imms;
    pc_seq   = pc + a64eu_pkg::PC_STEP;
    b_off    = {{36{word[25]}}, word[25:0], 2'b00};
    bc_off   = {{43{word[23]}}, word[23:5], 2'b00};
    if (word[23:22] != 2'b00) begin
      imm12 = {40'd0, word[21:10], 12'd0};
    end else begin
      imm12 = {52'd0, word[21:10]};
    end
    case (word[22:21])
      2'd0:    movz_val = {48'd0, word[20:5]};
      2'd1:    movz_val = {32'd0, word[20:5], 16'd0};
      2'd2:    movz_val = {16'd0, word[20:5], 32'd0};
      default: movz_val = {word[20:5], 48'd0};
    endcase
    case (word[3:0])
      a64eu_pkg::COND_EQ: cond_go = flag_z;
      a64eu_pkg::COND_NE: cond_go = !flag_z;
      a64eu_pkg::COND_GE: cond_go = !flag_n;
      a64eu_pkg::COND_LT: cond_go = flag_n;
      a64eu_pkg::COND_GT: cond_go = !flag_z && !flag_n;
      a64eu_pkg::COND_LE: cond_go = flag_z || flag_n;
      default:            cond_go = 1'b0;
    endcase
  end

  always_comb begin
    res           = '0;
    res.next_pc   = pc_seq;
    flag_src      = '0;
    case (op)
      a64eu_pkg::OP_ADDS_IMM: begin
        flag_src = rn_val + imm12;  res.write = 1'b1;  res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_ADDS_REG: begin
        flag_src = rn_val + rm_val; res.write = 1'b1;  res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_SUBS_IMM: begin
        flag_src = rn_val - imm12;  res.write = 1'b1;  res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_SUBS_REG: begin
        flag_src = rn_val - rm_val; res.write = 1'b1;  res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_CMP_IMM: begin
        flag_src = rn_val - imm12;  res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_CMP_REG: begin
        flag_src = rn_val - rm_val; res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_ANDS: begin
        flag_src = rn_val & rm_val; res.write = 1'b1;  res.set_flags = 1'b1;
      end
      a64eu_pkg::OP_EOR: begin
        res.value = rn_val ^ rm_val; res.write = 1'b1;
      end
      a64eu_pkg::OP_ORR: begin
        res.value = rn_val | rm_val; res.write = 1'b1;
      end
      a64eu_pkg::OP_B: begin
        res.next_pc = pc + b_off;   res.taken = 1'b1;
      end
      a64eu_pkg::OP_BR: begin
        res.next_pc = rn_val;       res.taken = 1'b1;
      end
      a64eu_pkg::OP_B_COND: begin
        if (cond_go) begin
          res.next_pc = pc + bc_off;
          res.taken   = 1'b1;
        end
      end
      a64eu_pkg::OP_SHIFT: begin
        if (imms == a64eu_pkg::SHIFT_RIGHT_SEL) begin
          res.value = rn_val >> immr;
        end else begin
          res.value = rn_val << lsl_amt;
        end
        res.write = 1'b1;
      end
      a64eu_pkg::OP_MOVZ: begin
        res.value = movz_val;       res.write = 1'b1;
      end
      a64eu_pkg::OP_ADD_IMM: begin
        res.value = rn_val + imm12; res.write = 1'b1;
      end
      a64eu_pkg::OP_ADD_REG: begin
        res.value = rn_val + rm_val; res.write = 1'b1;
      end
      a64eu_pkg::OP_MADD: begin
        res.value = madd_val;       res.write = 1'b1;
      end
      a64eu_pkg::OP_HLT: begin
        res.halt = 1'b1;
      end
      default: begin
        res.write = 1'b0;
      end
    endcase
    if (res.set_flags && res.write) begin
      res.value = flag_src;
    end
    if (res.set_flags) begin
      res.neg  = flag_src[a64eu_pkg::XLEN-1];
      res.zero = (flag_src == '0);
    end else begin
      res.neg  = flag_n;
      res.zero = flag_z;
    end
    // A stopped machine ignores the instruction entirely.
    if (!running) begin
      res         = '0;
      res.next_pc = pc;
      res.neg     = flag_n;
      res.zero    = flag_z;
    end
  end

endmodule

### rtl/arm64_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// arm64_subset_execute_unit
// Executes one instruction of a small A64 integer subset per input beat.
// ----------------------------------------------------------------------------
// Timing: the instruction and its register file reads are registered into the execute
// stage at acceptance, and the result beat is registered from there once the result
// channel is free; madd first registers 32x32 partial products of its 64x64 product
// and then commits. Throughput: one instruction per cycle while the result channel
// does not stall, except that madd holds the input while its partial products form.
// Reset: registers read zero, N and Z clear, pc takes the start value, running.
module arm64_subset_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  a64eu_in_if.sink           in_ch,
  a64eu_out_if.source        out_ch,
  a64eu_cfg_if.sink          cfg_ch
);

  localparam int XLEN   = a64eu_pkg::XLEN;
  localparam int HALF_W = a64eu_pkg::HALF_W;

  // Architectural state.
  logic [XLEN-1:0] pc_r;
  logic [XLEN-1:0] start_pc_r;
  logic [XLEN-1:0] start_pc_nxt;
  logic            flag_n_r;
  logic            flag_z_r;
  logic            running_r;

  // Execute stage.
  logic                              ex_valid_r;
  logic [a64eu_pkg::OP_W-1:0]        ex_op_r;
  logic [a64eu_pkg::WORD_W-1:0]      ex_word_r;
  logic                              mul_phase_r;
  logic [XLEN-1:0]                   pp_lo_r;
  logic [HALF_W-1:0]                 pp_x0_r;
  logic [HALF_W-1:0]                 pp_x1_r;
  logic [XLEN-1:0]                   rn_val;
  logic [XLEN-1:0]                   rm_val;
  logic [XLEN-1:0]                   ra_val;
  logic [XLEN-1:0]                   madd_val;
  logic [HALF_W-1:0]                 pp_cross;
  logic                              is_madd;
  logic                              commit;
  logic                              in_fire;
  logic                              out_free;
  logic                              rf_we;
  a64eu_pkg::alu_res_t               alu_res;

  // Result register.
  logic                              out_valid_r;
  logic [XLEN-1:0]                   out_next_pc_r;
  logic                              out_taken_r;
  logic                              out_written_r;
  logic [a64eu_pkg::REG_ADDR_W-1:0]  out_dest_index_r;
  logic [XLEN-1:0]                   out_dest_value_r;
  logic                              out_neg_r;
  logic                              out_zero_r;
  logic                              out_halted_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_madd  = (ex_op_r == a64eu_pkg::OP_MADD);
  // A madd whose partial products are not yet registered cannot commit.
  assign commit   = ex_valid_r && out_free && !(is_madd && !mul_phase_r);
  assign in_ch.ready  = !ex_valid_r || commit;
  assign cfg_ch.ready = 1'b1;

  assign rf_we = commit && alu_res.write && (ex_word_r[4:0] != a64eu_pkg::ZERO_REG);

  a64eu_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rn_addr (in_ch.instr_word[9:5]),
    .rm_addr (in_ch.instr_word[20:16]),
    .ra_addr (in_ch.instr_word[14:10]),
    .we      (rf_we),
    .waddr   (ex_word_r[4:0]),
    .wdata   (alu_res.value),
    .rn_data (rn_val),
    .rm_data (rm_val),
    .ra_data (ra_val)
  );

  // ra plus the low 64 bits of rn * rm: lo*lo plus the two cross products shifted up.
  assign pp_cross = pp_x0_r + pp_x1_r;
  assign madd_val = ra_val + pp_lo_r + {pp_cross, {HALF_W{1'b0}}};

  a64eu_alu u_alu (
    .op       (ex_op_r),
    .word     (ex_word_r),
    .rn_val   (rn_val),
    .rm_val   (rm_val),
    .madd_val (madd_val),
    .pc       (pc_r),
    .flag_n   (flag_n_r),
    .flag_z   (flag_z_r),
    .running  (running_r),
    .res      (alu_res)
  );

  always_ff @(posedge clk) begin
    if (ex_valid_r && is_madd && !mul_phase_r) begin
      pp_lo_r <= {{HALF_W{1'b0}}, rn_val[HALF_W-1:0]} * {{HALF_W{1'b0}}, rm_val[HALF_W-1:0]};
      pp_x0_r <= HALF_W'(rn_val[HALF_W-1:0] * rm_val[XLEN-1:HALF_W]);
      pp_x1_r <= HALF_W'(rn_val[XLEN-1:HALF_W] * rm_val[HALF_W-1:0]);
    end
  end

  always_comb begin
    if (!rst_n) begin
      start_pc_nxt = a64eu_pkg::START_PC_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      start_pc_nxt = cfg_ch.data;
    end else begin
      start_pc_nxt = start_pc_r;
    end
  end

  always_ff @(posedge clk) begin
    start_pc_r <= start_pc_nxt;
    if (!rst_n) begin
      pc_r      <= start_pc_nxt;
      flag_n_r  <= 1'b0;
      flag_z_r  <= 1'b0;
      running_r <= 1'b1;
    end else if (commit) begin
      pc_r     <= alu_res.next_pc;
      flag_n_r <= alu_res.neg;
      flag_z_r <= alu_res.zero;
      if (alu_res.halt) begin
        running_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      mul_phase_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ex_valid_r <= 1'b1;
      end else if (commit) begin
        ex_valid_r <= 1'b0;
      end
      if (commit) begin
        mul_phase_r <= 1'b0;
      end else if (ex_valid_r && is_madd) begin
        mul_phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_op_r   <= in_ch.op;
      ex_word_r <= in_ch.instr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_next_pc_r    <= alu_res.next_pc;
      out_taken_r      <= alu_res.taken;
      out_written_r    <= rf_we;
      out_dest_index_r <= rf_we ? ex_word_r[4:0] : '0;
      out_dest_value_r <= rf_we ? alu_res.value : '0;
      out_neg_r        <= alu_res.neg;
      out_zero_r       <= alu_res.zero;
      out_halted_r     <= !running_r || alu_res.halt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_pc      = out_next_pc_r;
  assign out_ch.branch_taken = out_taken_r;
  assign out_ch.reg_written  = out_written_r;
  assign out_ch.dest_index   = out_dest_index_r;
  assign out_ch.dest_value   = out_dest_value_r;
  assign out_ch.neg_flag     = out_neg_r;
  assign out_ch.zero_flag    = out_zero_r;
  assign out_ch.halted       = out_halted_r;

endmodule

### rtl/a64eu_checker.sv
// ----------------------------------------------------------------------------
// a64eu_checker
// Port-level checks on the result channel of the execute unit.
// ----------------------------------------------------------------------------
module a64eu_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [a64eu_pkg::XLEN-1:0]          next_pc,
  input logic                                branch_taken,
  input logic                                reg_written,
  input logic [a64eu_pkg::REG_ADDR_W-1:0]    dest_index,
  input logic [a64eu_pkg::XLEN-1:0]          dest_value,
  input logic                                halted
);

  logic                       seen_halt_r;
  logic [a64eu_pkg::XLEN-1:0] last_pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_pc_r <= next_pc;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(dest_value))
    else $error("result beat changed while stalled");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reg_written |-> dest_index == '0 && dest_value == '0)
    else $error("destination fields nonzero without a register write");

  a_zero_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reg_written |-> dest_index != a64eu_pkg::ZERO_REG)
    else $error("write reported to the zero register");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |->
      halted && !reg_written && !branch_taken && next_pc == last_pc_r)
    else $error("stopped machine changed state");

endmodule

bind arm64_subset_execute_unit a64eu_checker u_a64eu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .next_pc      (out_ch.next_pc),
  .branch_taken (out_ch.branch_taken),
  .reg_written  (out_ch.reg_written),
  .dest_index   (out_ch.dest_index),
  .dest_value   (out_ch.dest_value),
  .halted       (out_ch.halted)
);
